FILE: design/i2c_master_mem_access_assert.svh
// ----------------------------------------------------------------------------
// i2c_master_mem_access assertion macros
// shared concurrent assertion forms, clocked on i_clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_MEM_ACCESS_ASSERT_SVH
`define I2C_MASTER_MEM_ACCESS_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// types and constants shared by the i2c master blocks
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // transaction kinds carried in the request opcode
    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_READ      = 2'd1,
        KIND_REG_WRITE = 2'd2,
        KIND_REG_READ  = 2'd3
    } t_kind;

    // bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START1  = 4'd1,
        PH_TX_DEV1 = 4'd2,
        PH_TX_REGH = 4'd3,
        PH_TX_REGL = 4'd4,
        PH_START2  = 4'd5,
        PH_TX_DEV2 = 4'd6,
        PH_TX_DATA = 4'd7,
        PH_RX      = 4'd8,
        PH_MACK    = 4'd9,
        PH_GAP     = 4'd10,
        PH_STOP    = 4'd11
    } t_phase;

    localparam logic [7:0]  DIR_BIT           = 8'h01;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] GAP_TICKS         = 16'd2;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    // one tick request
    typedef struct packed {
        logic        request_valid;
        t_kind       opcode;
        logic [7:0]  device_address;
        logic [15:0] register_address;
        logic        wide_register_address;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
        logic        sda_sample;
    } t_in;

    // one tick result
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       take_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic       status;
    } t_out;

endpackage

FILE: design/i2c_master_mem_access.sv
// A request's result appears in the output register in the cycle after its acceptance.
// Throughput: one request per cycle; the sequencer step is a single registered pass.
// Input stalls only while a finished result is held by a stalled output.
// Reset (synchronous, active low): sequencer idle, output empty, ACK timeout 1000 ticks.
// ----------------------------------------------------------------------------
// i2c_master_mem_access
// tick-driven i2c master with plain and register read/write transactions
// ----------------------------------------------------------------------------
module i2c_master_mem_access (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  i2cm_pkg::t_in  i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output i2cm_pkg::t_out o_out_res
);

    logic           accept;
    logic           full;
    i2cm_pkg::t_out step_res;

    // request handshake
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    i2cm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_in_req),
        .o_res      (step_res)
    );

    i2cm_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res       (step_res),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_res       (o_out_res),
        .o_full      (full)
    );

endmodule

FILE: design/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// bus sequencer state and the per-tick step logic for the i2c master
// ----------------------------------------------------------------------------
`include "i2c_master_mem_access_assert.svh"

module i2cm_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  i2cm_pkg::t_in  i_req,
    output i2cm_pkg::t_out o_res
);

    i2cm_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_step, n_step;
    logic [3:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic [15:0]      r_bytes, n_bytes;
    logic [15:0]      r_ack, n_ack;
    i2cm_pkg::t_kind  r_kind, n_kind;
    logic [15:0]      r_reg_addr, n_reg_addr;
    logic             r_wide, n_wide;
    logic [7:0]       r_dev, n_dev;
    logic             r_failed, n_failed;
    logic [15:0]      r_timeout;

    i2cm_pkg::t_phase cur_phase;
    logic [1:0]       cur_step;
    logic [7:0]       tx_byte;
    logic [3:0]       bit_inc;
    logic [15:0]      ack_inc;
    logic [15:0]      bytes_dec;
    logic [7:0]       rx_byte;
    i2cm_pkg::t_out   res;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    // one tick of the sequencer
    always_comb begin
        n_phase    = r_phase;
        n_step     = r_step;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_bytes    = r_bytes;
        n_ack      = r_ack;
        n_kind     = r_kind;
        n_reg_addr = r_reg_addr;
        n_wide     = r_wide;
        n_dev      = r_dev;
        n_failed   = r_failed;

        res           = '0;
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
        res.busy_res  = 1'b1;

        cur_phase = r_phase;
        cur_step  = r_step;

        // new request on an idle tick, this tick is already the first start tick
        if (r_phase == i2cm_pkg::PH_IDLE && i_req.request_valid) begin
            n_kind     = i_req.opcode;
            n_dev      = i_req.device_address;
            n_reg_addr = i_req.register_address;
            n_wide     = i_req.wide_register_address;
            n_bytes    = i_req.byte_count;
            n_failed   = 1'b0;
            cur_phase  = i2cm_pkg::PH_START1;
            cur_step   = 2'd0;
            n_phase    = i2cm_pkg::PH_START1;
            n_step     = 2'd0;
        end

        tx_byte   = (cur_phase == i2cm_pkg::PH_TX_DATA && r_bit == 4'd0)
                    ? i_req.write_byte : r_shift;
        bit_inc   = r_bit + 4'd1;
        ack_inc   = r_ack + 16'd1;
        bytes_dec = r_bytes - 16'd1;
        rx_byte   = {r_shift[6:0], i_req.sda_sample};

        unique case (cur_phase)
            i2cm_pkg::PH_IDLE: begin
                res.busy_res = 1'b0;
            end
            i2cm_pkg::PH_START1, i2cm_pkg::PH_START2: begin
                if (cur_step == 2'd0) begin
                    n_step = 2'd1;
                end else begin
                    res.sda_level = 1'b0;
                    n_step        = 2'd0;
                    n_bit         = 4'd0;
                    n_phase       = (cur_phase == i2cm_pkg::PH_START2)
                                    ? i2cm_pkg::PH_TX_DEV2 : i2cm_pkg::PH_TX_DEV1;
                    if (cur_phase == i2cm_pkg::PH_START2 || r_kind == i2cm_pkg::KIND_READ)
                    begin
                        n_shift = r_dev | i2cm_pkg::DIR_BIT;
                    end else begin
                        n_shift = r_dev & ~i2cm_pkg::DIR_BIT;
                    end
                end
            end
            i2cm_pkg::PH_TX_DEV1, i2cm_pkg::PH_TX_REGH, i2cm_pkg::PH_TX_REGL,
            i2cm_pkg::PH_TX_DEV2, i2cm_pkg::PH_TX_DATA: begin
                unique case (cur_step)
                    2'd0: begin
                        // data bytes are fetched on their first bit
                        if (cur_phase == i2cm_pkg::PH_TX_DATA && r_bit == 4'd0) begin
                            res.take_byte = 1'b1;
                        end
                        n_shift       = tx_byte;
                        res.scl_level = 1'b0;
                        res.sda_level = tx_byte[7];
                        n_step        = 2'd1;
                    end
                    2'd1: begin
                        res.sda_level = r_shift[7];
                        n_shift       = {r_shift[6:0], 1'b0};
                        n_bit         = bit_inc;
                        n_step        = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ? 2'd2 : 2'd0;
                    end
                    2'd2: begin
                        res.scl_level = 1'b0;
                        n_ack         = 16'd0;
                        n_step        = 2'd3;
                    end
                    default: begin
                        if (!i_req.sda_sample) begin
                            // slave acked, move on by phase
                            unique case (cur_phase)
                                i2cm_pkg::PH_TX_DEV1: begin
                                    if (r_kind == i2cm_pkg::KIND_READ) begin
                                        if (r_bytes != 16'd0) begin
                                            n_phase = i2cm_pkg::PH_RX;
                                            n_step  = 2'd0;
                                            n_bit   = 4'd0;
                                            n_shift = 8'd0;
                                        end else begin
                                            n_phase = i2cm_pkg::PH_STOP;
                                            n_step  = 2'd0;
                                        end
                                    end else if (r_kind == i2cm_pkg::KIND_WRITE) begin
                                        n_phase = (r_bytes != 16'd0)
                                                  ? i2cm_pkg::PH_TX_DATA : i2cm_pkg::PH_STOP;
                                        n_step  = 2'd0;
                                        n_bit   = (r_bytes != 16'd0) ? 4'd0 : r_bit;
                                        n_shift = (r_bytes != 16'd0) ? 8'd0 : r_shift;
                                    end else begin
                                        n_phase = r_wide ? i2cm_pkg::PH_TX_REGH
                                                         : i2cm_pkg::PH_TX_REGL;
                                        n_step  = 2'd0;
                                        n_bit   = 4'd0;
                                        n_shift = r_wide ? r_reg_addr[15:8] : r_reg_addr[7:0];
                                    end
                                end
                                i2cm_pkg::PH_TX_REGH: begin
                                    n_phase = i2cm_pkg::PH_TX_REGL;
                                    n_step  = 2'd0;
                                    n_bit   = 4'd0;
                                    n_shift = r_reg_addr[7:0];
                                end
                                i2cm_pkg::PH_TX_REGL: begin
                                    if (r_kind == i2cm_pkg::KIND_REG_READ) begin
                                        n_phase = i2cm_pkg::PH_START2;
                                        n_step  = 2'd0;
                                    end else begin
                                        n_phase = (r_bytes != 16'd0)
                                                  ? i2cm_pkg::PH_TX_DATA : i2cm_pkg::PH_STOP;
                                        n_step  = 2'd0;
                                        n_bit   = (r_bytes != 16'd0) ? 4'd0 : r_bit;
                                        n_shift = (r_bytes != 16'd0) ? 8'd0 : r_shift;
                                    end
                                end
                                i2cm_pkg::PH_TX_DEV2: begin
                                    if (r_bytes != 16'd0) begin
                                        n_phase = i2cm_pkg::PH_RX;
                                        n_step  = 2'd0;
                                        n_bit   = 4'd0;
                                        n_shift = 8'd0;
                                    end else begin
                                        n_phase = i2cm_pkg::PH_STOP;
                                        n_step  = 2'd0;
                                    end
                                end
                                default: begin
                                    // data byte sent
                                    n_bytes = bytes_dec;
                                    if (r_kind == i2cm_pkg::KIND_REG_WRITE
                                        && i2cm_pkg::GAP_TICKS != 16'd0) begin
                                        n_phase = i2cm_pkg::PH_GAP;
                                        n_ack   = 16'd0;
                                    end else begin
                                        n_phase = (bytes_dec != 16'd0)
                                                  ? i2cm_pkg::PH_TX_DATA : i2cm_pkg::PH_STOP;
                                        n_step  = 2'd0;
                                        n_bit   = (bytes_dec != 16'd0) ? 4'd0 : r_bit;
                                        n_shift = (bytes_dec != 16'd0) ? 8'd0 : r_shift;
                                    end
                                end
                            endcase
                        end else begin
                            // still no ack, count toward the timeout
                            n_ack = ack_inc;
                            if (ack_inc == r_timeout) begin
                                n_failed = 1'b1;
                                n_phase  = i2cm_pkg::PH_STOP;
                                n_step   = 2'd0;
                            end
                        end
                    end
                endcase
            end
            i2cm_pkg::PH_RX: begin
                if (cur_step == 2'd0) begin
                    res.scl_level = 1'b0;
                    n_step        = 2'd1;
                end else begin
                    n_shift = rx_byte;
                    n_bit   = bit_inc;
                    n_step  = 2'd0;
                    if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = rx_byte;
                        n_bytes        = bytes_dec;
                        n_phase        = i2cm_pkg::PH_MACK;
                    end
                end
            end
            i2cm_pkg::PH_MACK: begin
                // ack every byte but the last
                res.sda_level = (r_bytes == 16'd0);
                if (cur_step == 2'd0) begin
                    res.scl_level = 1'b0;
                    n_step        = 2'd1;
                end else if (r_bytes != 16'd0) begin
                    n_phase = i2cm_pkg::PH_RX;
                    n_step  = 2'd0;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                end else begin
                    n_phase = i2cm_pkg::PH_STOP;
                    n_step  = 2'd0;
                end
            end
            i2cm_pkg::PH_GAP: begin
                res.scl_level = 1'b0;
                n_ack         = ack_inc;
                if (ack_inc >= i2cm_pkg::GAP_TICKS) begin
                    n_phase = (r_bytes != 16'd0) ? i2cm_pkg::PH_TX_DATA : i2cm_pkg::PH_STOP;
                    n_step  = 2'd0;
                    n_bit   = (r_bytes != 16'd0) ? 4'd0 : r_bit;
                    n_shift = (r_bytes != 16'd0) ? 8'd0 : r_shift;
                end
            end
            default: begin
                // stop condition
                if (cur_step == 2'd0) begin
                    res.scl_level = 1'b0;
                    res.sda_level = 1'b0;
                    n_step        = 2'd1;
                end else if (cur_step == 2'd1) begin
                    res.sda_level = 1'b0;
                    n_step        = 2'd2;
                end else begin
                    res.done_res = 1'b1;
                    res.status   = r_failed;
                    n_phase      = i2cm_pkg::PH_IDLE;
                    n_step       = 2'd0;
                end
            end
        endcase
    end

    assign o_res = res;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= i2cm_pkg::PH_IDLE;
            r_step     <= 2'd0;
            r_bit      <= 4'd0;
            r_bytes    <= 16'd0;
            r_ack      <= 16'd0;
            r_kind     <= i2cm_pkg::KIND_WRITE;
            r_wide     <= 1'b0;
            r_failed   <= 1'b0;
            r_shift    <= 8'd0;
            r_reg_addr <= 16'd0;
            r_dev      <= 8'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_step     <= n_step;
            r_bit      <= n_bit;
            r_bytes    <= n_bytes;
            r_ack      <= n_ack;
            r_kind     <= n_kind;
            r_wide     <= n_wide;
            r_failed   <= n_failed;
            r_shift    <= n_shift;
            r_reg_addr <= n_reg_addr;
            r_dev      <= n_dev;
        end
    end

    // checks
    `I2CM_ASSERT_SAME(a_bit_range, 1'b1, r_bit <= i2cm_pkg::BITS_PER_BYTE, "bit index past byte")
    `I2CM_ASSERT_NEXT(a_done_idle, i_accept && res.done_res, r_phase == i2cm_pkg::PH_IDLE,
        "done without return to idle")
    `I2CM_ASSERT_NEXT(a_rx_mack, i_accept && res.read_valid, r_phase == i2cm_pkg::PH_MACK,
        "received byte not followed by master ack")
    `I2CM_ASSERT_SAME(a_take_tx, res.take_byte,
        r_phase == i2cm_pkg::PH_TX_DATA && r_bit == 4'd0 && r_step == 2'd0,
        "write byte taken outside data bit zero")

endmodule

FILE: design/i2cm_out_reg.sv
// ----------------------------------------------------------------------------
// i2cm_out_reg
// result register between the sequencer and the output channel
// ----------------------------------------------------------------------------
module i2cm_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  i2cm_pkg::t_out i_res,
    input  logic           i_out_stall,
    output logic           o_valid,
    output i2cm_pkg::t_out o_res,
    output logic           o_full
);

    logic           r_valid, n_valid;
    i2cm_pkg::t_out r_res;

    // held result blocks new requests
    assign o_full = r_valid && i_out_stall;

    always_comb begin
        n_valid = i_load || o_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: tb/tb_i2c_master_mem_access.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_mem_access
// feeds bus ticks to the i2c master while an emulated slave answers acks and
// supplies read data; a local model predicts each tick's bus drive, busy,
// byte handshake and completion status, and every result is compared in order
// ----------------------------------------------------------------------------
module tb_i2c_master_mem_access;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ACK_ALWAYS  = 32'hFFFF_FFFF;

    // dut connections
    logic              i_clk       = 1'b1;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [15:0]       i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    i2cm_pkg::t_in     i_in_req    = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    i2cm_pkg::t_out    o_out_res;

    i2c_master_mem_access dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b0;
        #4 i_clk = 1'b1;
    end

    // predicted bus sequencer state
    i2cm_pkg::t_phase bus_phase     = i2cm_pkg::PH_IDLE;
    logic [2:0]       step_cnt      = '0;
    logic [3:0]       bit_cnt       = '0;
    logic [7:0]       shreg         = '0;
    logic [15:0]      bytes_left    = '0;
    logic [15:0]      ack_wait      = '0;
    i2cm_pkg::t_kind  xfer_kind     = i2cm_pkg::KIND_WRITE;
    logic [15:0]      reg_addr      = '0;
    logic             wide_addr     = 1'b0;
    logic [7:0]       dev_byte      = '0;
    logic             fail_flag     = 1'b0;
    logic [15:0]      timeout_ticks = i2cm_pkg::ACK_TIMEOUT_RESET;

    // expected per-tick results, oldest first
    i2cm_pkg::t_out   tick_expect[$];
    i2cm_pkg::t_out   head_exp;
    int unsigned      mismatches = 0;
    int unsigned      sent_ticks = 0;
    int unsigned      idle_cycles = 0;

    // idling and emulated slave behavior
    int unsigned send_gap_pct   = 35;
    int unsigned recv_stall_pct = 54;
    int unsigned ack_left       = ACK_ALWAYS;
    int unsigned late_pct       = 0;
    int unsigned data_pat       = 0;

    function automatic void load_byte(input i2cm_pkg::t_phase ph, input logic [7:0] b);
        bus_phase = ph;
        step_cnt  = '0;
        bit_cnt   = '0;
        shreg     = b;
    endfunction

    function automatic void enter_stop();
        bus_phase = i2cm_pkg::PH_STOP;
        step_cnt  = '0;
    endfunction

    function automatic void data_or_stop();
        if (bytes_left != 0) load_byte(i2cm_pkg::PH_TX_DATA, 8'h00);
        else enter_stop();
    endfunction

    function automatic void read_or_stop();
        if (bytes_left != 0) begin
            bus_phase = i2cm_pkg::PH_RX;
            step_cnt  = '0;
            bit_cnt   = '0;
            shreg     = '0;
        end else begin
            enter_stop();
        end
    endfunction

    // one bus tick of the master: returns the expected drive and flags
    function automatic i2cm_pkg::t_out tick_predict(input i2cm_pkg::t_in rq);
        i2cm_pkg::t_out rs;
        rs           = '0;
        rs.scl_level = 1'b1;
        rs.sda_level = 1'b1;
        rs.busy_res  = 1'b1;

        // request taken only on an idle tick, which is also the first start tick
        if (bus_phase == i2cm_pkg::PH_IDLE && rq.request_valid) begin
            xfer_kind  = rq.opcode;
            dev_byte   = rq.device_address;
            reg_addr   = rq.register_address;
            wide_addr  = rq.wide_register_address;
            bytes_left = rq.byte_count;
            fail_flag  = 1'b0;
            bus_phase  = i2cm_pkg::PH_START1;
            step_cnt   = '0;
        end

        case (bus_phase)
            i2cm_pkg::PH_IDLE: begin
                rs.busy_res = 1'b0;
            end
            i2cm_pkg::PH_START1, i2cm_pkg::PH_START2: begin
                if (step_cnt == 0) begin
                    step_cnt = 3'd1;
                end else begin
                    rs.sda_level = 1'b0;
                    if (bus_phase == i2cm_pkg::PH_START2)
                        load_byte(i2cm_pkg::PH_TX_DEV2, dev_byte | i2cm_pkg::DIR_BIT);
                    else if (xfer_kind == i2cm_pkg::KIND_READ)
                        load_byte(i2cm_pkg::PH_TX_DEV1, dev_byte | i2cm_pkg::DIR_BIT);
                    else
                        load_byte(i2cm_pkg::PH_TX_DEV1, dev_byte & ~i2cm_pkg::DIR_BIT);
                end
            end
            i2cm_pkg::PH_TX_DEV1, i2cm_pkg::PH_TX_REGH, i2cm_pkg::PH_TX_REGL,
            i2cm_pkg::PH_TX_DEV2, i2cm_pkg::PH_TX_DATA: begin
                case (step_cnt)
                    3'd0: begin
                        if (bus_phase == i2cm_pkg::PH_TX_DATA && bit_cnt == 0) begin
                            shreg         = rq.write_byte;
                            rs.take_byte  = 1'b1;
                        end
                        rs.scl_level = 1'b0;
                        rs.sda_level = shreg[7];
                        step_cnt     = 3'd1;
                    end
                    3'd1: begin
                        rs.sda_level = shreg[7];
                        shreg        = shreg << 1;
                        bit_cnt      = bit_cnt + 4'd1;
                        step_cnt     = (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd0;
                    end
                    3'd2: begin
                        rs.scl_level = 1'b0;
                        ack_wait     = '0;
                        step_cnt     = 3'd3;
                    end
                    default: begin
                        if (!rq.sda_sample) begin
                            // slave acked: move on to the next byte, the repeated start, the gap or the stop
                            case (bus_phase)
                                i2cm_pkg::PH_TX_DEV1: begin
                                    if (xfer_kind == i2cm_pkg::KIND_READ)
                                        read_or_stop();
                                    else if (xfer_kind == i2cm_pkg::KIND_WRITE)
                                        data_or_stop();
                                    else if (wide_addr)
                                        load_byte(i2cm_pkg::PH_TX_REGH, reg_addr[15:8]);
                                    else
                                        load_byte(i2cm_pkg::PH_TX_REGL, reg_addr[7:0]);
                                end
                                i2cm_pkg::PH_TX_REGH:
                                    load_byte(i2cm_pkg::PH_TX_REGL, reg_addr[7:0]);
                                i2cm_pkg::PH_TX_REGL: begin
                                    if (xfer_kind == i2cm_pkg::KIND_REG_READ) begin
                                        bus_phase = i2cm_pkg::PH_START2;
                                        step_cnt  = '0;
                                    end else begin
                                        data_or_stop();
                                    end
                                end
                                i2cm_pkg::PH_TX_DEV2: read_or_stop();
                                default: begin
                                    bytes_left = bytes_left - 16'd1;
                                    if (xfer_kind == i2cm_pkg::KIND_REG_WRITE
                                        && i2cm_pkg::GAP_TICKS > 0) begin
                                        bus_phase = i2cm_pkg::PH_GAP;
                                        ack_wait  = '0;
                                    end else begin
                                        data_or_stop();
                                    end
                                end
                            endcase
                        end else begin
                            ack_wait = ack_wait + 16'd1;
                            if (ack_wait == timeout_ticks) begin
                                fail_flag = 1'b1;
                                enter_stop();
                            end
                        end
                    end
                endcase
            end
            i2cm_pkg::PH_RX: begin
                if (step_cnt == 0) begin
                    rs.scl_level = 1'b0;
                    step_cnt     = 3'd1;
                end else begin
                    shreg   = {shreg[6:0], rq.sda_sample};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
                        rs.read_valid = 1'b1;
                        rs.read_byte  = shreg;
                        bytes_left    = bytes_left - 16'd1;
                        bus_phase     = i2cm_pkg::PH_MACK;
                    end
                    step_cnt = '0;
                end
            end
            i2cm_pkg::PH_MACK: begin
                // nack only after the last byte
                rs.sda_level = (bytes_left == 0);
                if (step_cnt == 0) begin
                    rs.scl_level = 1'b0;
                    step_cnt     = 3'd1;
                end else begin
                    read_or_stop();
                end
            end
            i2cm_pkg::PH_GAP: begin
                rs.scl_level = 1'b0;
                ack_wait     = ack_wait + 16'd1;
                if (ack_wait >= i2cm_pkg::GAP_TICKS) data_or_stop();
            end
            default: begin
                if (step_cnt == 0) begin
                    rs.scl_level = 1'b0;
                    rs.sda_level = 1'b0;
                    step_cnt     = 3'd1;
                end else if (step_cnt == 1) begin
                    rs.sda_level = 1'b0;
                    step_cnt     = 3'd2;
                end else begin
                    rs.done_res = 1'b1;
                    rs.status   = fail_flag;
                    bus_phase   = i2cm_pkg::PH_IDLE;
                    step_cnt    = '0;
                end
            end
        endcase
        return rs;
    endfunction

    // emulated slave: sda level for the next tick from the predicted state
    function automatic logic slave_sda();
        if (bus_phase inside {i2cm_pkg::PH_TX_DEV1, i2cm_pkg::PH_TX_REGH,
                              i2cm_pkg::PH_TX_REGL, i2cm_pkg::PH_TX_DEV2,
                              i2cm_pkg::PH_TX_DATA}
                && step_cnt == 3'd3) begin
            if (ack_left == 0) return 1'b1;
            if ($urandom_range(99) < late_pct) return 1'b1;
            if (ack_left != ACK_ALWAYS) ack_left--;
            return 1'b0;
        end
        case (data_pat)
            1: return 1'b0;
            2: return 1'b1;
            default: return 1'($urandom_range(1));
        endcase
    endfunction

    function automatic i2cm_pkg::t_in random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(i2cm_pkg::t_in)-1:0];
    endfunction

    // send one request; predict its result once it is accepted
    task automatic send_item(input i2cm_pkg::t_in rq);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= rq;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tick_expect.push_back(tick_predict(rq));
        sent_ticks++;
        @(negedge i_clk);
    endtask

    // fill in the slave side of a tick and send it
    task automatic bus_tick(input i2cm_pkg::t_in rq);
        rq.sda_sample = slave_sda();
        if (data_pat == 1) rq.write_byte = 8'h00;
        else if (data_pat == 2) rq.write_byte = 8'hFF;
        send_item(rq);
    endtask

    task automatic idle_ticks(input int unsigned n);
        i2cm_pkg::t_in rq;
        repeat (n) begin
            rq               = random_item();
            rq.request_valid = 1'b0;
            bus_tick(rq);
        end
    endtask

    // one whole transaction from request to stop
    task automatic run_transfer(input i2cm_pkg::t_kind op, input logic [7:0] dev,
                                input logic [15:0] rga,
                                input logic wide, input logic [15:0] count,
                                input int unsigned acks, input int unsigned late,
                                input int unsigned pat, input bit noisy);
        i2cm_pkg::t_in rq;
        ack_left = acks;
        late_pct = late;
        data_pat = pat;
        rq                       = random_item();
        rq.request_valid         = 1'b1;
        rq.opcode                = op;
        rq.device_address        = dev;
        rq.register_address      = rga;
        rq.wide_register_address = wide;
        rq.byte_count            = count;
        bus_tick(rq);
        // busy ticks, optionally carrying requests that must be ignored
        while (bus_phase != i2cm_pkg::PH_IDLE) begin
            rq = noisy ? random_item() : i2cm_pkg::t_in'('0);
            bus_tick(rq);
        end
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tick_expect.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        timeout_ticks  = value;
        @(negedge i_clk);
    endtask

    // slow acks under the timeout left by reset
    task automatic test_reset_timeout();
        run_transfer(i2cm_pkg::KIND_WRITE, 8'hA5, 16'h0000, 1'b0, 16'd1,
                     ACK_ALWAYS, 90, 0, 1'b0);
    endtask

    // every kind with address, byte and count extremes
    task automatic test_each_kind();
        write_timeout(16'd5);
        run_transfer(i2cm_pkg::KIND_WRITE,     8'h00, 16'h0000, 1'b0, 16'd0,
                     ACK_ALWAYS, 10, 0, 1'b0);
        run_transfer(i2cm_pkg::KIND_WRITE,     8'hFF, 16'hFFFF, 1'b1, 16'd2,
                     ACK_ALWAYS, 10, 2, 1'b0);
        run_transfer(i2cm_pkg::KIND_WRITE,     8'h00, 16'h0000, 1'b0, 16'd2,
                     ACK_ALWAYS, 10, 1, 1'b0);
        run_transfer(i2cm_pkg::KIND_READ,      8'h00, 16'h0000, 1'b0, 16'd0,
                     ACK_ALWAYS, 10, 0, 1'b0);
        run_transfer(i2cm_pkg::KIND_READ,      8'hFE, 16'h0000, 1'b0, 16'd3,
                     ACK_ALWAYS, 10, 1, 1'b0);
        run_transfer(i2cm_pkg::KIND_READ,      8'hFF, 16'hFFFF, 1'b1, 16'd3,
                     ACK_ALWAYS, 10, 2, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_WRITE, 8'hFF, 16'hFFFF, 1'b1, 16'd2,
                     ACK_ALWAYS, 10, 0, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_WRITE, 8'h00, 16'h0000, 1'b0, 16'd0,
                     ACK_ALWAYS, 10, 1, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_WRITE, 8'h5A, 16'hFF00, 1'b0, 16'd1,
                     ACK_ALWAYS, 10, 2, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_READ,  8'hFF, 16'hFFFF, 1'b1, 16'd2,
                     ACK_ALWAYS, 10, 2, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_READ,  8'h00, 16'h1234, 1'b0, 16'd1,
                     ACK_ALWAYS, 10, 1, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_READ,  8'h81, 16'h00FF, 1'b1, 16'd0,
                     ACK_ALWAYS, 10, 0, 1'b0);
    endtask

    // requests offered on every busy tick must not disturb the transaction
    task automatic test_busy_requests();
        run_transfer(i2cm_pkg::KIND_REG_READ, 8'h3C, 16'hA55A, 1'b1, 16'd2,
                     ACK_ALWAYS, 10, 0, 1'b1);
        run_transfer(i2cm_pkg::KIND_WRITE,    8'hC3, 16'h0000, 1'b0, 16'd1,
                     ACK_ALWAYS, 10, 0, 1'b1);
    endtask

    // aborts at each ack point, the largest timeout and the wrapped zero timeout
    task automatic test_ack_timeouts();
        write_timeout(16'd1);
        run_transfer(i2cm_pkg::KIND_REG_WRITE, 8'h20, 16'hBEEF, 1'b1, 16'd2,
                     1, 0, 0, 1'b0);
        run_transfer(i2cm_pkg::KIND_WRITE,     8'h21, 16'h0000, 1'b0, 16'hFFFF,
                     3, 0, 0, 1'b0);
        run_transfer(i2cm_pkg::KIND_REG_READ,  8'h22, 16'h0042, 1'b0, 16'd2,
                     2, 0, 0, 1'b0);
        write_timeout(16'hFFFF);
        run_transfer(i2cm_pkg::KIND_REG_WRITE, 8'h23, 16'h8001, 1'b1, 16'd2,
                     ACK_ALWAYS, 80, 0, 1'b0);
        write_timeout(16'h0000);
        run_transfer(i2cm_pkg::KIND_READ,      8'h25, 16'h0000, 1'b0, 16'd2,
                     ACK_ALWAYS, 30, 0, 1'b0);
    endtask

    // random transactions under three idling mixes and timeouts
    task automatic test_random_traffic();
        int unsigned     ph;
        int unsigned     stop_at;
        int unsigned     r;
        int unsigned     acks;
        int unsigned     late;
        int unsigned     pat;
        i2cm_pkg::t_kind op;
        logic [15:0]     count;
        bit              read_kind;
        bit              small_tmo;
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 35;
                    recv_stall_pct = 54;
                    write_timeout(16'($urandom_range(2, 12)));
                end
                1: begin
                    send_gap_pct   = 54;
                    recv_stall_pct = 35;
                    write_timeout(16'd1);
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    write_timeout(16'hFFFF);
                end
            endcase
            small_tmo = (timeout_ticks != 0) && (timeout_ticks <= 16);
            stop_at   = sent_ticks + 120;
            while (sent_ticks < stop_at) begin
                if ($urandom_range(3) == 0) idle_ticks($urandom_range(1, 4));
                op        = i2cm_pkg::t_kind'($urandom_range(3));
                read_kind = (op == i2cm_pkg::KIND_READ) || (op == i2cm_pkg::KIND_REG_READ);
                r         = $urandom_range(99);
                // mostly short transfers; huge writes only where a nack ends them soon
                if (r < 70) count = 16'($urandom_range(0, 3));
                else if (r < 90 || read_kind || !small_tmo) count = 16'($urandom_range(4, 8));
                else count = 16'($urandom);
                if (small_tmo && (count > 8 || $urandom_range(99) < 15))
                    acks = $urandom_range(0, 6);
                else
                    acks = ACK_ALWAYS;
                late = (timeout_ticks == 1) ? $urandom_range(0, 4) : $urandom_range(0, 30);
                r    = $urandom_range(19);
                pat  = (r == 0) ? 1 : (r == 1) ? 2 : 0;
                run_transfer(op, 8'($urandom), 16'($urandom), 1'($urandom_range(1)), count,
                             acks, late, pat, bit'($urandom_range(1)));
            end
        end
    endtask

    // receiver side stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tick_expect.size() == 0) begin
                $error("result with no request waiting");
                mismatches++;
            end else begin
                head_exp = tick_expect.pop_front();
                check_field("scl_level",  head_exp.scl_level,  o_out_res.scl_level);
                check_field("sda_level",  head_exp.sda_level,  o_out_res.sda_level);
                check_field("busy_res",   head_exp.busy_res,   o_out_res.busy_res);
                check_field("take_byte",  head_exp.take_byte,  o_out_res.take_byte);
                check_field("read_valid", head_exp.read_valid, o_out_res.read_valid);
                check_field("read_byte",  head_exp.read_byte,  o_out_res.read_byte);
                check_field("done_res",   head_exp.done_res,   o_out_res.done_res);
                check_field("status",     head_exp.status,     o_out_res.status);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("i2c_master_mem_access regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_timeout();
        test_each_kind();
        test_busy_requests();
        test_ack_timeouts();
        test_random_traffic();
        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("i2c_master_mem_access regression: pass");
        end else begin
            $display("i2c_master_mem_access regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2cm_out_reg.sv
design/i2c_master_mem_access.sv
tb/tb_i2c_master_mem_access.sv
